FILE: src/tsched_pkg.sv
package tsched_pkg;

    localparam int THREADS_DEFAULT = 8;
    localparam int PRIO_W          = 8;
    localparam int OUT_IDX_W       = 3;
    // One table entry holds the slot state, the priority and the starvation count.
    localparam int ENTRY_W_DEFAULT = 2 + PRIO_W + $clog2(THREADS_DEFAULT + 1);

    typedef enum logic [1:0] {
        SLOT_UNUSED  = 2'd0,
        SLOT_READY   = 2'd1,
        SLOT_RUNNING = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_YIELD  = 2'd1,
        OP_CREATE = 2'd2,
        OP_EXIT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_SELECTED = 2'd0,
        RES_NO_READY = 2'd1,
        RES_CREATED  = 2'd2,
        RES_FULL     = 2'd3
    } result_t;

    // Context that the sequencer hands to the slot unit for every entry it visits.
    typedef struct packed {
        op_t               op;
        logic              mode;
        logic              cur_valid;
        logic              found;
        logic [PRIO_W-1:0] min_prio;
    } unit_ctl_t;

endpackage

FILE: src/thread_scheduler_rr_priority_aging_core.sv
// Channel   Handshake          Payload
// --------  -----------------  ------------------------------------------------
// command   start / busy       opcode, priority_req
// result    done (one cycle)   status, thread_index, running_valid, running_index
// config    cfg_we             cfg_wdata (mode)
//
// Tick, yield and exit make two passes from acceptance to done: one pass
// over the slot table to pick, one read-modify-write pass to age and update.
// Create makes one pass to find a free slot, then gives the result.
// Both passes share one slot unit and one table RAM, one slot per cycle.
// The table needs no clearing pass after reset: per-slot valid bits cover it.
// busy drops in the cycle done is shown; the receiver cannot stall.
module thread_scheduler_rr_priority_aging_core #(
    parameter int THREADS = tsched_pkg::THREADS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           opcode,
    input  logic [tsched_pkg::PRIO_W-1:0]        priority_req,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [tsched_pkg::OUT_IDX_W-1:0]     thread_index,
    output logic                                 running_valid,
    output logic [tsched_pkg::OUT_IDX_W-1:0]     running_index
);

    localparam int IW = $clog2(THREADS);
    localparam int CW = $clog2(THREADS + 1);
    localparam int PW = tsched_pkg::PRIO_W;
    localparam int EW = 2 + PW + CW;
    localparam int OW = tsched_pkg::OUT_IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    tsched_pkg::op_t         op_reg, op_next;
    logic [PW-1:0]           prio_req_reg, prio_req_next;
    logic                    mode_reg, mode_next;
    logic                    cur_valid_reg, cur_valid_next;
    logic [IW-1:0]           cur_reg, cur_next;
    logic [THREADS-1:0]      ent_valid_reg, ent_valid_next;
    logic [IW-1:0]           addr_reg, addr_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    pv_reg, pv_next;
    logic [IW-1:0]           pidx_reg, pidx_next;
    logic                    plast_reg, plast_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic                    found_reg, found_next;
    logic [PW-1:0]           min_prio_reg, min_prio_next;
    logic [IW-1:0]           chosen_reg, chosen_next;
    logic                    done_reg, done_next;
    tsched_pkg::result_t     status_reg, status_next;
    logic [OW-1:0]           thread_index_reg, thread_index_next;
    logic                    running_valid_reg, running_valid_next;
    logic [OW-1:0]           running_index_reg, running_index_next;

    logic                    issue;
    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic [EW-1:0]           ram_q;
    logic [EW-1:0]           rd_word;
    logic [IW-1:0]           rr_start;
    logic                    new_valid;
    tsched_pkg::unit_ctl_t   ctl;
    logic                    take;
    tsched_pkg::slot_state_t u_st;
    logic [PW-1:0]           u_prio;
    logic [CW-1:0]           u_cnt;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
        wrap_inc = (a == IW'(THREADS - 1)) ? '0 : a + IW'(1);
    endfunction

    tsched_ram #(
        .WIDTH (EW),
        .DEPTH (THREADS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    // A slot that was never written reads as unused with zero priority and count.
    assign rd_word = rd_ok_reg ? ram_q : '0;

    assign ctl.op        = op_reg;
    assign ctl.mode      = mode_reg;
    assign ctl.cur_valid = cur_valid_reg;
    assign ctl.found     = found_reg;
    assign ctl.min_prio  = min_prio_reg;

    tsched_slot_unit #(
        .THREADS (THREADS)
    ) u_slot (
        .ctl      (ctl),
        .idx      (pidx_reg),
        .cur      (cur_reg),
        .chosen   (chosen_reg),
        .st_in    (rd_word[EW-1 -: 2]),
        .prio_in  (rd_word[CW +: PW]),
        .cnt_in   (rd_word[CW-1:0]),
        .take     (take),
        .st_out   (u_st),
        .prio_out (u_prio),
        .cnt_out  (u_cnt)
    );

    assign rr_start = (tsched_pkg::op_t'(opcode) != tsched_pkg::OP_EXIT && cur_valid_reg)
                      ? cur_reg : '0;

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        prio_req_next      = prio_req_reg;
        mode_next          = cfg_we ? cfg_wdata : mode_reg;
        cur_valid_next     = cur_valid_reg;
        cur_next           = cur_reg;
        ent_valid_next     = ent_valid_reg;
        addr_next          = addr_reg;
        cnt_next           = cnt_reg;
        found_next         = found_reg;
        min_prio_next      = min_prio_reg;
        chosen_next        = chosen_reg;
        done_next          = 1'b0;
        status_next        = status_reg;
        thread_index_next  = thread_index_reg;
        running_valid_next = running_valid_reg;
        running_index_next = running_index_reg;
        ram_we             = 1'b0;
        ram_waddr          = pidx_reg;
        ram_wdata          = {u_st, u_prio, u_cnt};
        new_valid          = cur_valid_reg;

        issue      = (state_reg != ST_IDLE) && (cnt_reg != CW'(THREADS));
        pv_next    = issue;
        pidx_next  = addr_reg;
        plast_next = issue && (cnt_reg == CW'(THREADS - 1));
        rd_ok_next = ent_valid_reg[addr_reg];
        if (issue)
        begin
            addr_next = wrap_inc(addr_reg);
            cnt_next  = cnt_reg + CW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next        = tsched_pkg::op_t'(opcode);
                    prio_req_next  = priority_req;
                    found_next     = 1'b0;
                    cnt_next       = '0;
                    state_next     = ST_SCAN;
                    // Round robin starts one past the current slot (at slot one for an exit
                    // or with no current thread); other searches run upward from slot zero.
                    if (tsched_pkg::op_t'(opcode) != tsched_pkg::OP_CREATE && !mode_reg)
                    begin
                        addr_next = wrap_inc(rr_start);
                    end
                    else
                    begin
                        addr_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pv_reg && take)
                begin
                    found_next     = 1'b1;
                    min_prio_next  = rd_word[CW +: PW];
                    chosen_next    = pidx_reg;
                end
                if (pv_reg && plast_reg)
                begin
                    if (op_reg == tsched_pkg::OP_CREATE)
                    begin
                        state_next         = ST_IDLE;
                        done_next          = 1'b1;
                        running_valid_next = cur_valid_reg;
                        running_index_next = cur_valid_reg ? OW'(cur_reg) : '0;
                        if (found_next)
                        begin
                            ram_we                     = 1'b1;
                            ram_waddr                  = chosen_next;
                            ram_wdata                  = {tsched_pkg::SLOT_READY,
                                                          prio_req_reg, CW'(0)};
                            ent_valid_next[chosen_next] = 1'b1;
                            status_next                = tsched_pkg::RES_CREATED;
                            thread_index_next          = OW'(chosen_next);
                        end
                        else
                        begin
                            status_next       = tsched_pkg::RES_FULL;
                            thread_index_next = '0;
                        end
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                        addr_next  = '0;
                        cnt_next   = '0;
                    end
                end
            end
            ST_WRITE:
            begin
                if (pv_reg)
                begin
                    ram_we                   = 1'b1;
                    ram_waddr                = pidx_reg;
                    ent_valid_next[pidx_reg] = 1'b1;
                end
                if (pv_reg && plast_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (found_reg)
                    begin
                        cur_valid_next     = 1'b1;
                        cur_next           = chosen_reg;
                        status_next        = tsched_pkg::RES_SELECTED;
                        thread_index_next  = OW'(chosen_reg);
                        running_valid_next = 1'b1;
                        running_index_next = OW'(chosen_reg);
                    end
                    else
                    begin
                        // Nothing was picked; only an exit changes the current thread.
                        new_valid = cur_valid_reg && (op_reg != tsched_pkg::OP_EXIT);
                        cur_valid_next     = new_valid;
                        cur_next           = new_valid ? cur_reg : '0;
                        status_next        = tsched_pkg::RES_NO_READY;
                        thread_index_next  = '0;
                        running_valid_next = new_valid;
                        running_index_next = new_valid ? OW'(cur_reg) : '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
            ent_valid_reg <= '0;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cur_valid_reg <= cur_valid_next;
            cur_reg       <= cur_next;
            ent_valid_reg <= ent_valid_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        prio_req_reg      <= prio_req_next;
        addr_reg          <= addr_next;
        pidx_reg          <= pidx_next;
        plast_reg         <= plast_next;
        rd_ok_reg         <= rd_ok_next;
        min_prio_reg      <= min_prio_next;
        chosen_reg        <= chosen_next;
        status_reg        <= status_next;
        thread_index_reg  <= thread_index_next;
        running_valid_reg <= running_valid_next;
        running_index_reg <= running_index_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign thread_index  = thread_index_reg;
    assign running_valid = running_valid_reg;
    assign running_index = running_index_reg;

`ifndef SYNTHESIS
    a_done_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_WRITE))
        else $error("result strobe without a finished pass");

    a_selected_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == tsched_pkg::RES_SELECTED) |->
        (running_valid_reg && running_index_reg == thread_index_reg))
        else $error("selected thread is not the running thread");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != ST_IDLE))
        else $error("table written while idle");

    a_current_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(cur_valid_reg))
        else $error("current thread changed while idle");
`endif

endmodule

FILE: src/tsched_ram.sv
module tsched_ram #(
    parameter int WIDTH = tsched_pkg::ENTRY_W_DEFAULT,
    parameter int DEPTH = tsched_pkg::THREADS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tsched_slot_unit.sv
module tsched_slot_unit #(
    parameter int THREADS = tsched_pkg::THREADS_DEFAULT
) (
    input  tsched_pkg::unit_ctl_t               ctl,
    input  logic [$clog2(THREADS)-1:0]          idx,
    input  logic [$clog2(THREADS)-1:0]          cur,
    input  logic [$clog2(THREADS)-1:0]          chosen,
    input  logic [1:0]                          st_in,
    input  logic [tsched_pkg::PRIO_W-1:0]       prio_in,
    input  logic [$clog2(THREADS+1)-1:0]        cnt_in,
    output logic                                take,
    output tsched_pkg::slot_state_t             st_out,
    output logic [tsched_pkg::PRIO_W-1:0]       prio_out,
    output logic [$clog2(THREADS+1)-1:0]        cnt_out
);

    localparam int CW = $clog2(THREADS + 1);

    tsched_pkg::slot_state_t eff;
    logic [CW-1:0]           cnt_inc;

    always_comb
    begin
        // The pending yield or exit of the current thread is applied on the fly,
        // so the table itself is only written in the final pass.
        eff = tsched_pkg::slot_state_t'(st_in);
        if (ctl.cur_valid && idx == cur)
        begin
            case (ctl.op)
                tsched_pkg::OP_YIELD: eff = tsched_pkg::SLOT_READY;
                tsched_pkg::OP_EXIT:  eff = tsched_pkg::SLOT_UNUSED;
                default:              eff = tsched_pkg::slot_state_t'(st_in);
            endcase
        end

        if (ctl.op == tsched_pkg::OP_CREATE)
        begin
            take = (eff == tsched_pkg::SLOT_UNUSED) && !ctl.found;
        end
        else
        begin
            take = (eff == tsched_pkg::SLOT_READY) &&
                   (!ctl.found || (ctl.mode && prio_in < ctl.min_prio));
        end

        st_out   = eff;
        prio_out = prio_in;
        cnt_out  = cnt_in;
        cnt_inc  = (cnt_in < CW'(THREADS)) ? cnt_in + CW'(1) : cnt_in;
        if (ctl.found)
        begin
            if (idx == chosen)
            begin
                st_out = tsched_pkg::SLOT_RUNNING;
            end
            else
            begin
                if (eff == tsched_pkg::SLOT_READY)
                begin
                    if (cnt_inc >= CW'(THREADS) && prio_in != '0)
                    begin
                        prio_out = prio_in - tsched_pkg::PRIO_W'(1);
                        cnt_out  = '0;
                    end
                    else
                    begin
                        cnt_out = cnt_inc;
                    end
                end
                // The thread that loses the processor goes back to ready.
                if (ctl.cur_valid && ctl.op != tsched_pkg::OP_EXIT && idx == cur)
                begin
                    st_out = tsched_pkg::SLOT_READY;
                end
            end
        end
    end

endmodule
